### src/assert_macros.svh
// Assertion macros shared by the date stepper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CDS_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("%m: check failed");

// Check that a condition is followed by another in the next cycle.
`define CDS_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("%m: check failed");

`endif

### src/cds_pkg.sv
// Types, codes and calendar constants for the date stepper.
`timescale 1ns / 1ps

package cds_pkg;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  new_month;
        logic [4:0]  new_day;
        logic [15:0] new_year;
        logic [15:0] day_count;
    } t_cds_cmd;

    typedef struct packed {
        logic [3:0]  cur_month;
        logic [4:0]  cur_day;
        logic [15:0] cur_year;
        logic [2:0]  status;
    } t_cds_res;

    localparam logic [1:0] MODE_SET = 2'd0;
    localparam logic [1:0] MODE_ADD = 2'd1;
    localparam logic [1:0] MODE_SUB = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_MONTH = 3'd1;
    localparam logic [2:0] ST_BAD_YEAR  = 3'd2;
    localparam logic [2:0] ST_BAD_DAY   = 3'd3;
    localparam logic [2:0] ST_RANGE     = 3'd4;

    localparam logic [15:0] MIN_SET_YEAR = 16'd1753;
    localparam logic [15:0] MAX_YEAR     = 16'd65535;
    localparam logic [15:0] MIN_YEAR     = 16'd1;
    localparam logic [3:0]  MONTH_FIRST  = 4'd1;
    localparam logic [3:0]  MONTH_LAST   = 4'd12;
    localparam logic [4:0]  DAY_FIRST    = 5'd1;
    localparam logic [4:0]  DAY_DEC_LAST = 5'd31;

    // y is a multiple of 25 exactly when y * inverse(25) mod 2^16 <= floor(65535 / 25)
    localparam logic [15:0] INV25     = 16'd23593;
    localparam logic [15:0] DIV25_LIM = 16'd2621;

    function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

### src/cds_chan_if.sv
// Valid/ready channel carrying one payload transaction per handshake.
`timescale 1ns / 1ps

interface cds_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### src/calendar_date_stepper_unit.sv
// Gregorian date register with set, add-days and subtract-days commands.
// Set goes from S_IDLE straight to S_DONE on a bad month or year, else through S_SET; mode 3 goes straight to S_DONE.
// Add/subtract pass through S_STEP, one day per cycle through the stepper, until the count is spent or the range ends.
// A new command is taken only after the result is accepted; ready only while idle.
// Reset (synchronous, active low): date 1/1/2000, sequencer idle, no result pending.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module calendar_date_stepper_unit #(
    parameter int COUNT_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cds_chan_if.sink   i_cmd,
    cds_chan_if.source o_res
);
    import cds_pkg::*;

    localparam int CNT_W = (COUNT_BITS < 16) ? COUNT_BITS : 16;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SET  = 4'b0010,
        S_STEP = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state           r_state,   n_state;
    logic [3:0]       r_month,   n_month;
    logic [4:0]       r_day,     n_day;
    logic [15:0]      r_year,    n_year;
    logic [2:0]       r_status,  n_status;
    logic [4:0]       r_new_day, n_new_day;
    logic [CNT_W-1:0] r_cnt,     n_cnt;
    logic             r_back,    n_back;

    logic [15:0] w_prod;
    logic        w_div25;
    logic        w_leap;
    logic [3:0]  w_mon_sel;
    logic [4:0]  w_dim;
    t_cds_cmd    w_cmd;

    assign w_cmd   = i_cmd.payload;
    assign w_prod  = r_year * INV25;
    assign w_div25 = (w_prod <= DIV25_LIM);
    assign w_leap  = (r_year[1:0] == 2'b00) && (!w_div25 || (r_year[3:0] == 4'b0000));

    assign w_mon_sel = ((r_state == S_STEP) && r_back) ? (r_month - 4'd1) : r_month;
    assign w_dim     = days_in(w_mon_sel, w_leap);

    always_comb begin
        n_state   = r_state;
        n_month   = r_month;
        n_day     = r_day;
        n_year    = r_year;
        n_status  = r_status;
        n_new_day = r_new_day;
        n_cnt     = r_cnt;
        n_back    = r_back;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_status = ST_OK;
                    case (w_cmd.mode)
                        MODE_SET: begin
                            if ((w_cmd.new_month < MONTH_FIRST) ||
                                (w_cmd.new_month > MONTH_LAST)) begin
                                n_status = ST_BAD_MONTH;
                                n_state  = S_DONE;
                            end else if (w_cmd.new_year < MIN_SET_YEAR) begin
                                n_month  = w_cmd.new_month;
                                n_status = ST_BAD_YEAR;
                                n_state  = S_DONE;
                            end else begin
                                n_month   = w_cmd.new_month;
                                n_year    = w_cmd.new_year;
                                n_new_day = w_cmd.new_day;
                                n_state   = S_SET;
                            end
                        end
                        MODE_ADD: begin
                            n_cnt   = w_cmd.day_count[CNT_W-1:0];
                            n_back  = 1'b0;
                            n_state = S_STEP;
                        end
                        MODE_SUB: begin
                            n_cnt   = w_cmd.day_count[CNT_W-1:0];
                            n_back  = 1'b1;
                            n_state = S_STEP;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SET: begin
                if ((r_new_day >= DAY_FIRST) && (r_new_day <= w_dim)) begin
                    n_day = r_new_day;
                end else begin
                    n_status = ST_BAD_DAY;
                end
                n_state = S_DONE;
            end
            S_STEP: begin
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                    if (!r_back) begin
                        if (r_day < w_dim) begin
                            n_day = r_day + 5'd1;
                        end else if (r_month < MONTH_LAST) begin
                            n_month = r_month + 4'd1;
                            n_day   = DAY_FIRST;
                        end else if (r_year >= MAX_YEAR) begin
                            n_status = ST_RANGE;
                            n_state  = S_DONE;
                        end else begin
                            n_year  = r_year + 16'd1;
                            n_month = MONTH_FIRST;
                            n_day   = DAY_FIRST;
                        end
                    end else begin
                        if (r_day > DAY_FIRST) begin
                            n_day = r_day - 5'd1;
                        end else if (r_month > MONTH_FIRST) begin
                            n_month = w_mon_sel;
                            n_day   = w_dim;
                        end else if (r_year <= MIN_YEAR) begin
                            n_status = ST_RANGE;
                            n_state  = S_DONE;
                        end else begin
                            n_year  = r_year - 16'd1;
                            n_month = MONTH_LAST;
                            n_day   = DAY_DEC_LAST;
                        end
                    end
                end
            end
            S_DONE: begin
                if (o_res.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_month  <= MONTH_FIRST;
            r_day    <= DAY_FIRST;
            r_year   <= 16'd2000;
            r_status <= ST_OK;
            r_cnt    <= '0;
            r_back   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_month  <= n_month;
            r_day    <= n_day;
            r_year   <= n_year;
            r_status <= n_status;
            r_cnt    <= n_cnt;
            r_back   <= n_back;
        end
    end

    always_ff @(posedge i_clk) begin
        r_new_day <= n_new_day;
    end

    assign i_cmd.ready               = (r_state == S_IDLE);
    assign o_res.valid               = (r_state == S_DONE);
    assign o_res.payload.cur_month   = r_month;
    assign o_res.payload.cur_day     = r_day;
    assign o_res.payload.cur_year    = r_year;
    assign o_res.payload.status      = r_status;

    `CDS_ASSERT_NEXT(a_busy_after_accept, i_cmd.valid && i_cmd.ready, !i_cmd.ready)
    `CDS_ASSERT(a_month_in_range, (r_month >= MONTH_FIRST) && (r_month <= MONTH_LAST))
    `CDS_ASSERT(a_day_nonzero, r_day != 5'd0)
    `CDS_ASSERT_NEXT(a_cnt_end, r_state == S_STEP && r_cnt == '0, o_res.valid && r_status == ST_OK)

endmodule

### tb/tb.sv
// Self-checking testbench for the calendar date stepper: set, add-days, subtract-days and mode 3.
`timescale 1ns / 1ps

module tb;
    import cds_pkg::*;

    localparam logic [1:0] MODE_NOP    = 2'd3;
    localparam int         CYCLE_LIMIT = 6_000_000;
    localparam int         DRAIN_WAIT  = 20;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cds_chan_if #(.T(t_cds_cmd)) cmd_ch ();
    cds_chan_if #(.T(t_cds_res)) res_ch ();

    calendar_date_stepper_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    t_cds_cmd pending_cmds[$];
    t_cds_res expected_dates[$];

    logic [3:0]  cal_month = MONTH_FIRST;
    logic [4:0]  cal_day   = DAY_FIRST;
    logic [15:0] cal_year  = 16'd2000;

    int  sent_count   = 0;
    int  results_seen = 0;
    int  errors       = 0;
    int  cycle_count  = 0;
    int  hold_left    = 0;
    bit  hold_done    = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic is_leap(input logic [15:0] y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function automatic logic [4:0] month_length(input logic [3:0] m, input logic [15:0] y);
        logic [4:0] len;
        case (m)
            4'd2:                    len = is_leap(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic bit advance_day();
        if (cal_day < month_length(cal_month, cal_year)) begin
            cal_day = cal_day + 1'b1;
        end else if (cal_month < MONTH_LAST) begin
            cal_month = cal_month + 1'b1;
            cal_day   = DAY_FIRST;
        end else if (cal_year == MAX_YEAR) begin
            return 1'b0;
        end else begin
            cal_year  = cal_year + 1'b1;
            cal_month = MONTH_FIRST;
            cal_day   = DAY_FIRST;
        end
        return 1'b1;
    endfunction

    function automatic bit rewind_day();
        if (cal_day > DAY_FIRST) begin
            cal_day = cal_day - 1'b1;
        end else if (cal_month > MONTH_FIRST) begin
            cal_month = cal_month - 1'b1;
            cal_day   = month_length(cal_month, cal_year);
        end else if (cal_year == MIN_YEAR) begin
            return 1'b0;
        end else begin
            cal_year  = cal_year - 1'b1;
            cal_month = MONTH_LAST;
            cal_day   = DAY_DEC_LAST;
        end
        return 1'b1;
    endfunction

    function automatic t_cds_res predict_date(input t_cds_cmd c);
        t_cds_res r;
        int       n;
        r.status = ST_OK;
        n = 0;
        case (c.mode)
            MODE_SET: begin
                if (c.new_month < MONTH_FIRST || c.new_month > MONTH_LAST) begin
                    r.status = ST_BAD_MONTH;
                end else begin
                    cal_month = c.new_month;
                    if (c.new_year < MIN_SET_YEAR) begin
                        r.status = ST_BAD_YEAR;
                    end else begin
                        cal_year = c.new_year;
                        if (c.new_day >= DAY_FIRST &&
                            c.new_day <= month_length(cal_month, cal_year))
                            cal_day = c.new_day;
                        else
                            r.status = ST_BAD_DAY;
                    end
                end
            end
            MODE_ADD: begin
                while (n < c.day_count && r.status == ST_OK) begin
                    if (!advance_day()) r.status = ST_RANGE;
                    n++;
                end
            end
            MODE_SUB: begin
                while (n < c.day_count && r.status == ST_OK) begin
                    if (!rewind_day()) r.status = ST_RANGE;
                    n++;
                end
            end
            default: ;
        endcase
        r.cur_month = cal_month;
        r.cur_day   = cal_day;
        r.cur_year  = cal_year;
        return r;
    endfunction

    function automatic t_cds_cmd date_cmd(input logic [1:0] mode, input int m, input int d,
                                          input int y, input int count);
        t_cds_cmd c;
        c.mode      = mode;
        c.new_month = 4'(m);
        c.new_day   = 5'(d);
        c.new_year  = 16'(y);
        c.day_count = 16'(count);
        return c;
    endfunction

    function automatic t_cds_cmd random_command();
        t_cds_cmd c;
        int       pick;
        c.new_month = 4'($urandom_range(15));
        c.new_day   = 5'($urandom_range(31));
        c.new_year  = 16'($urandom_range(65535));
        c.day_count = 16'($urandom_range(65535));
        pick = int'($urandom_range(99));
        if (pick < 35) begin
            c.mode = MODE_SET;
            if ($urandom_range(99) < 65) begin
                pick = int'($urandom_range(99));
                c.new_month = 4'($urandom_range(12, 1));
                if (pick < 40)
                    c.new_year = 16'($urandom_range(2500, 1753));
                else if (pick < 60)
                    c.new_year = 16'($urandom_range(65535, 65530));
                else
                    c.new_year = 16'($urandom_range(65535, 1753));
                c.new_day = 5'($urandom_range(month_length(c.new_month, c.new_year), 1));
            end else if ($urandom_range(2) == 0) begin
                c.new_year = 16'($urandom_range(1752));
            end
        end else if (pick < 95) begin
            c.mode = (pick < 65) ? MODE_ADD : MODE_SUB;
            pick = int'($urandom_range(99));
            if (pick < 65)
                c.day_count = 16'($urandom_range(40));
            else if (pick < 90)
                c.day_count = 16'($urandom_range(800));
            else if (pick < 98)
                c.day_count = 16'($urandom_range(4000));
        end else begin
            c.mode = MODE_NOP;
        end
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_cmds.size() != 0 || cmd_ch.valid || expected_dates.size() != 0);
    endtask

    always @(posedge i_clk) begin : drive_cmd
        bit       offer;
        t_cds_cmd item;
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else begin
            offer = cmd_ch.valid;
            item  = cmd_ch.payload;
            if (cmd_ch.valid && cmd_ch.ready) begin
                expected_dates.push_back(predict_date(cmd_ch.payload));
                sent_count <= sent_count + 1;
                offer = 1'b0;
            end
            if (!offer && pending_cmds.size() != 0 &&
                ((sent_count >= 60 && sent_count < 80) || $urandom_range(99) >= 33)) begin
                item  = pending_cmds.pop_front();
                offer = 1'b1;
            end
            cmd_ch.valid   <= offer;
            cmd_ch.payload <= item;
        end
    end

    always @(posedge i_clk) begin : hold_off
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen == 40) begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : watch_res
        t_cds_res got;
        t_cds_res want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                got = res_ch.payload;
                results_seen <= results_seen + 1;
                if (expected_dates.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no command pending", results_seen));
                end else begin
                    want = expected_dates.pop_front();
                    if (got.cur_month !== want.cur_month)
                        report_mismatch($sformatf("result %0d month %0d, want %0d",
                                                  results_seen, got.cur_month, want.cur_month));
                    if (got.cur_day !== want.cur_day)
                        report_mismatch($sformatf("result %0d day %0d, want %0d",
                                                  results_seen, got.cur_day, want.cur_day));
                    if (got.cur_year !== want.cur_year)
                        report_mismatch($sformatf("result %0d year %0d, want %0d",
                                                  results_seen, got.cur_year, want.cur_year));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("result %0d status %0d, want %0d",
                                                  results_seen, got.status, want.status));
                end
            end
            res_ch.ready <= (hold_left == 0) &&
                            ((results_seen >= 60 && results_seen < 80) || $urandom_range(99) >= 33);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : stimulus
        int k;
        cmd_ch.valid   = 1'b0;
        cmd_ch.payload = '0;
        res_ch.ready   = 1'b0;
        i_rst_n        = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        pending_cmds.push_back(date_cmd(MODE_NOP, 15, 31, 65535, 65535));
        pending_cmds.push_back(date_cmd(MODE_ADD, 0, 0, 0, 0));
        pending_cmds.push_back(date_cmd(MODE_SET, 2, 29, 2000, 0));
        pending_cmds.push_back(date_cmd(MODE_ADD, 0, 0, 0, 1));
        pending_cmds.push_back(date_cmd(MODE_SET, 2, 29, 1900, 0));
        pending_cmds.push_back(date_cmd(MODE_SET, 0, 10, 2010, 0));
        pending_cmds.push_back(date_cmd(MODE_SET, 15, 10, 2010, 0));
        pending_cmds.push_back(date_cmd(MODE_SET, 13, 10, 2010, 0));
        pending_cmds.push_back(date_cmd(MODE_SET, 12, 31, 1752, 0));
        pending_cmds.push_back(date_cmd(MODE_SET, 1, 31, 2001, 0));
        pending_cmds.push_back(date_cmd(MODE_SET, 2, 5, 0, 0));
        pending_cmds.push_back(date_cmd(MODE_SUB, 0, 0, 0, 2));
        pending_cmds.push_back(date_cmd(MODE_ADD, 0, 0, 0, 1));
        pending_cmds.push_back(date_cmd(MODE_SET, 4, 31, 2001, 0));
        pending_cmds.push_back(date_cmd(MODE_SET, 3, 0, 2001, 0));
        pending_cmds.push_back(date_cmd(MODE_SET, 12, 31, 65535, 0));
        pending_cmds.push_back(date_cmd(MODE_ADD, 0, 0, 0, 1));
        pending_cmds.push_back(date_cmd(MODE_SET, 12, 20, 65535, 0));
        pending_cmds.push_back(date_cmd(MODE_ADD, 15, 31, 65535, 65535));
        pending_cmds.push_back(date_cmd(MODE_SET, 1, 1, 1753, 0));
        pending_cmds.push_back(date_cmd(MODE_SUB, 0, 0, 0, 1));
        pending_cmds.push_back(date_cmd(MODE_SET, 2, 29, 2100, 0));
        pending_cmds.push_back(date_cmd(MODE_SET, 2, 29, 2400, 0));
        pending_cmds.push_back(date_cmd(MODE_SUB, 0, 0, 0, 0));
        wait_drained();

        for (k = 0; k < 63; k++)
            pending_cmds.push_back(random_command());
        wait_drained();

        // walk back from the earliest settable year until the year range runs out
        pending_cmds.push_back(date_cmd(MODE_SET, 1, 1, 1753, 0));
        for (k = 0; k < 10; k++)
            pending_cmds.push_back(date_cmd(MODE_SUB, 0, 0, 0, 65535));
        pending_cmds.push_back(date_cmd(MODE_SUB, 0, 0, 0, 1));
        pending_cmds.push_back(date_cmd(MODE_ADD, 0, 0, 0, 1));
        wait_drained();

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
